### sv/softened_gravity_force_accumulator_top_macros.svh
// Assertion macros for the softened gravity force accumulator.
// Used by the top level; each macro expects clk_i and rst_ni in scope.
`ifndef SOFTENED_GRAVITY_FORCE_ACCUMULATOR_TOP_MACROS_SVH
`define SOFTENED_GRAVITY_FORCE_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define SGFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SGFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sgfa_pkg.sv
// Shared types, constants and helpers (saturating add, magnitude) of the gravity accumulator.
// No dependencies.
package sgfa_pkg;

  localparam int unsigned MagW  = 32;
  localparam int unsigned SumW  = 64;
  localparam int unsigned ProdW = 96;
  localparam int unsigned NumW  = 128;

  localparam logic [SumW-1:0] SatMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [SumW-1:0] SatMin = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_ACCUM  = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic {
    CFG_SOFTENING = 1'b0,
    CFG_GRAV      = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_DEN,
    ST_NUM,
    ST_DIV,
    ST_ADD
  } state_e;

  typedef struct packed {
    logic            ovf;
    logic [SumW-1:0] val;
  } sat_t;

  typedef struct packed {
    logic mul_done;
    logic root_done;
    logic div_done;
  } unit_status_t;

  function automatic sat_t sat_add(input logic [SumW-1:0] a, input logic [SumW-1:0] b);
    logic [SumW-1:0] s;
    sat_t            r;
    s = a + b;
    r.ovf = (a[SumW-1] == b[SumW-1]) && (s[SumW-1] != a[SumW-1]);
    r.val = r.ovf ? (a[SumW-1] ? SatMin : SatMax) : s;
    return r;
  endfunction

  function automatic logic [MagW-1:0] magnitude(input logic [MagW-1:0] raw);
    return raw[MagW-1] ? (~raw + 32'd1) : raw;
  endfunction

endpackage

### sv/sgfa_sermul.sv
// Bit-serial shift-add multiplier: 64-bit by 32-bit, one multiplier bit per cycle.
// Depends on sgfa_pkg.
module sgfa_sermul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [63:0]                  a_i,
  input  logic [31:0]                  b_i,
  output logic                         done_o,
  output logic [sgfa_pkg::ProdW-1:0]   prod_o
);

  logic [64:0] hi_q, hi_d;
  logic [31:0] lo_q, lo_d;
  logic [63:0] a_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] sum;

  assign sum    = hi_q + {1'b0, (lo_q[0] ? a_q : 64'd0)};
  assign hi_d   = {1'b0, sum[64:1]};
  assign lo_d   = {sum[0], lo_q[31:1]};
  assign done_o = done_q;
  assign prod_o = {hi_q[63:0], lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= b_i;
      a_q  <= a_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

endmodule

### sv/sgfa_isqrt.sv
// Digit-by-digit integer square root of a 64-bit value, two radicand bits per cycle.
// Uses nothing from sgfa_pkg; stands alone.
module sgfa_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] rad_q;
  logic [32:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [34:0] trial_rem, trial, diff;
  logic        ge;

  assign trial_rem = {rem_q, rad_q[63:62]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign ge        = trial_rem >= trial;
  assign diff      = trial_rem - trial;
  assign done_o    = done_q;
  assign root_o    = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= ge ? diff[32:0] : trial_rem[32:0];
      root_q <= {root_q[30:0], ge};
    end
  end

endmodule

### sv/sgfa_serdiv.sv
// Restoring divider, 128-bit numerator by 96-bit denominator, one quotient bit per cycle.
// Keeps the low 64 quotient bits and flags any higher set bit. Depends on sgfa_pkg.
module sgfa_serdiv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sgfa_pkg::NumW-1:0]   num_i,
  input  logic [sgfa_pkg::ProdW-1:0]  den_i,
  output logic                        done_o,
  output logic [sgfa_pkg::SumW-1:0]   quot_o,
  output logic                        big_o
);

  logic [sgfa_pkg::NumW-1:0]  num_q;
  logic [sgfa_pkg::ProdW-1:0] den_q, rem_q;
  logic [sgfa_pkg::SumW-1:0]  quot_q;
  logic                       big_q;
  logic [6:0]                 cnt_q;
  logic                       busy_q, done_q;
  logic [sgfa_pkg::ProdW:0]   part, diff;
  logic                       ge;

  assign part   = {rem_q, num_q[sgfa_pkg::NumW-1]};
  assign ge     = part >= {1'b0, den_q};
  assign diff   = part - {1'b0, den_q};
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign big_o  = big_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
      big_q  <= 1'b0;
    end else if (busy_q) begin
      num_q  <= {num_q[sgfa_pkg::NumW-2:0], 1'b0};
      rem_q  <= ge ? diff[sgfa_pkg::ProdW-1:0] : part[sgfa_pkg::ProdW-1:0];
      quot_q <= {quot_q[sgfa_pkg::SumW-2:0], ge};
      big_q  <= big_q | quot_q[sgfa_pkg::SumW-1];
    end
  end

endmodule

### sv/softened_gravity_force_accumulator_top.sv
// Top level of the softened gravity force accumulator: sequencer, sums, ports.
// Depends on sgfa_pkg, sgfa_sermul, sgfa_isqrt, sgfa_serdiv and the macros header.
//
//   Channel  Direction  Beat contents
//   s_axis   in         tuser: func; tdata: delta_x/y/z, source_mass, tail_x/y/z
//   m_axis   out        tuser: saturated; tdata: accel_x/y/z
//   cfg      in         cfg_index_i selects the register, cfg_data_i is written
//
// An accumulate request runs the squared deltas, then the square root beside the G*mass
// product, the denominator, the three numerators and the divide, one bit or digit a cycle.
// Clear zeroes the sums; finish registers the sums plus tails and also zeroes the sums.
// A finish request waits while a result is still held and m_axis_tready_i is low.
// Reset is asynchronous, active low; the sums clear at once.
`include "softened_gravity_force_accumulator_top_macros.svh"

module softened_gravity_force_accumulator_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [31:0] delta_x, [63:32] delta_y, [95:64] delta_z, [127:96] source_mass,
  // [191:128] tail_x, [255:192] tail_y, [319:256] tail_z
  input  logic [319:0] s_axis_tdata_i,
  // [1:0] func
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [63:0] accel_x, [127:64] accel_y, [191:128] accel_z
  output logic [191:0] m_axis_tdata_o,
  // [0] saturated
  output logic [0:0]   m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned SumW = sgfa_pkg::SumW;

  sgfa_pkg::state_e state_q, state_d;
  sgfa_pkg::func_e  in_func;
  sgfa_pkg::unit_status_t st;

  logic        in_accept;
  logic [31:0] soft_q, grav_q, mass_q;
  logic [31:0] mag_in [3];
  logic [31:0] mag_q  [3];
  logic        neg_q  [3];
  logic [SumW-1:0] sum_q [3];
  logic [SumW-1:0] tail [3];
  logic [SumW-1:0] contrib_q [3];
  logic [SumW-1:0] contrib_d [3];
  logic [2:0]  contrib_ovf_q, contrib_ovf_d;
  logic        flag_q;
  logic [63:0] r2_q, r2_d, soft_shift, gm_q;
  logic [95:0] den_q;

  logic [2:0]  mul_start, mul_done, div_done;
  logic [63:0] mul_a [3];
  logic [31:0] mul_b [3];
  logic [95:0] prod  [3];
  logic [63:0] quot  [3];
  logic [2:0]  big;
  logic        root_start, root_done, div_start;
  logic [31:0] root;

  logic        out_valid_q;
  logic [191:0] out_data_q;
  logic        out_sat_q;
  sgfa_pkg::sat_t fin [3];
  sgfa_pkg::sat_t acc [3];

  assign in_func   = sgfa_pkg::func_e'(s_axis_tuser_i);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == sgfa_pkg::ST_IDLE) &&
                           ((in_func != sgfa_pkg::FUNC_FINISH) || !out_valid_q ||
                            m_axis_tready_i);
  assign cfg_ready_o = 1'b1;
  assign soft_shift  = {32'd0, soft_q} << FRAC_BITS;
  assign r2_d = prod[0][63:0] + prod[1][63:0] + prod[2][63:0] + soft_shift;

  assign st.mul_done  = mul_done[0];
  assign st.root_done = root_done;
  assign st.div_done  = div_done[0];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign mag_in[i] = sgfa_pkg::magnitude(s_axis_tdata_i[32*i +: 32]);
    assign tail[i]   = s_axis_tdata_i[128 + 64*i +: 64];
    assign fin[i]    = sgfa_pkg::sat_add(sum_q[i], tail[i]);
    assign acc[i]    = sgfa_pkg::sat_add(sum_q[i], contrib_q[i]);

    always_comb begin
      contrib_ovf_d[i] = big[i] || (neg_q[i] ? (quot[i] > sgfa_pkg::SatMin)
                                             : (quot[i] > sgfa_pkg::SatMax));
      if (contrib_ovf_d[i]) begin
        contrib_d[i] = neg_q[i] ? sgfa_pkg::SatMin : sgfa_pkg::SatMax;
      end else begin
        contrib_d[i] = neg_q[i] ? (~quot[i] + 64'd1) : quot[i];
      end
    end

    sgfa_sermul u_mul (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (mul_start[i]),
      .a_i     (mul_a[i]),
      .b_i     (mul_b[i]),
      .done_o  (mul_done[i]),
      .prod_o  (prod[i])
    );

    sgfa_serdiv u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   ({prod[i], 32'd0}),
      .den_i   (den_q),
      .done_o  (div_done[i]),
      .quot_o  (quot[i]),
      .big_o   (big[i])
    );
  end

  sgfa_isqrt u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (r2_d),
    .done_o  (root_done),
    .root_o  (root)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sgfa_pkg::ST_IDLE: begin
        if (in_accept && in_func == sgfa_pkg::FUNC_ACCUM) begin
          state_d = sgfa_pkg::ST_SQ;
        end
      end
      sgfa_pkg::ST_SQ: begin
        if (st.mul_done) begin
          state_d = (r2_d == 64'd0) ? sgfa_pkg::ST_IDLE : sgfa_pkg::ST_ROOT;
        end
      end
      sgfa_pkg::ST_ROOT: begin
        if (st.root_done) begin
          state_d = sgfa_pkg::ST_DEN;
        end
      end
      sgfa_pkg::ST_DEN: begin
        if (st.mul_done) begin
          state_d = sgfa_pkg::ST_NUM;
        end
      end
      sgfa_pkg::ST_NUM: begin
        if (st.mul_done) begin
          state_d = sgfa_pkg::ST_DIV;
        end
      end
      sgfa_pkg::ST_DIV: begin
        if (st.div_done) begin
          state_d = sgfa_pkg::ST_ADD;
        end
      end
      sgfa_pkg::ST_ADD: state_d = sgfa_pkg::ST_IDLE;
      default:          state_d = sgfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start  = '0;
    root_start = 1'b0;
    div_start  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mul_a[i] = {32'd0, mag_in[i]};
      mul_b[i] = mag_in[i];
    end
    unique case (state_q)
      sgfa_pkg::ST_IDLE: begin
        if (in_accept && in_func == sgfa_pkg::FUNC_ACCUM) begin
          mul_start = '1;
        end
      end
      sgfa_pkg::ST_SQ: begin
        mul_a[0] = {32'd0, grav_q};
        mul_b[0] = mass_q;
        if (st.mul_done && r2_d != 64'd0) begin
          mul_start[0] = 1'b1;
          root_start   = 1'b1;
        end
      end
      sgfa_pkg::ST_ROOT: begin
        mul_a[0] = r2_q;
        mul_b[0] = root;
        mul_start[0] = st.root_done;
      end
      sgfa_pkg::ST_DEN: begin
        for (int i = 0; i < 3; i++) begin
          mul_a[i] = gm_q;
          mul_b[i] = mag_q[i];
        end
        if (st.mul_done) begin
          mul_start = '1;
        end
      end
      sgfa_pkg::ST_NUM: div_start = st.mul_done;
      sgfa_pkg::ST_DIV, sgfa_pkg::ST_ADD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sgfa_pkg::ST_IDLE;
      soft_q      <= 32'd0;
      grav_q      <= 32'd65536;
      out_valid_q <= 1'b0;
      flag_q      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (sgfa_pkg::cfg_e'(cfg_index_i))
          sgfa_pkg::CFG_SOFTENING: soft_q <= cfg_data_i;
          sgfa_pkg::CFG_GRAV:      grav_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_accept && in_func == sgfa_pkg::FUNC_FINISH) begin
        out_valid_q <= 1'b1;
      end
      if (in_accept && (in_func == sgfa_pkg::FUNC_CLEAR ||
                        in_func == sgfa_pkg::FUNC_FINISH)) begin
        flag_q <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= '0;
        end
      end
      if (state_q == sgfa_pkg::ST_ADD) begin
        flag_q <= flag_q | (|contrib_ovf_q) | acc[0].ovf | acc[1].ovf | acc[2].ovf;
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= acc[i].val;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && in_func == sgfa_pkg::FUNC_ACCUM) begin
      mass_q <= s_axis_tdata_i[127:96];
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= mag_in[i];
        neg_q[i] <= s_axis_tdata_i[32*i + 31];
      end
    end
    if (in_accept && in_func == sgfa_pkg::FUNC_FINISH) begin
      out_data_q <= {fin[2].val, fin[1].val, fin[0].val};
      out_sat_q  <= flag_q | fin[0].ovf | fin[1].ovf | fin[2].ovf;
    end
    if (state_q == sgfa_pkg::ST_SQ && st.mul_done) begin
      r2_q <= r2_d;
    end
    if (state_q == sgfa_pkg::ST_ROOT && st.root_done) begin
      gm_q <= prod[0][63:0];
    end
    if (state_q == sgfa_pkg::ST_DEN && st.mul_done) begin
      den_q <= prod[0];
    end
    if (state_q == sgfa_pkg::ST_DIV && st.div_done) begin
      contrib_ovf_q <= contrib_ovf_d;
      for (int i = 0; i < 3; i++) begin
        contrib_q[i] <= contrib_d[i];
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sat_q;

  `SGFA_ASSERT_SAME(a_root_mul_align, state_q == sgfa_pkg::ST_ROOT, root_done == mul_done[0], "square root and multiplier out of step")
  `SGFA_ASSERT_SAME(a_lanes_align, div_done[0] || (state_q == sgfa_pkg::ST_NUM && mul_done[0]), (div_done == {3{div_done[0]}}) && (mul_done == {3{mul_done[0]}}), "lanes out of step")
  `SGFA_ASSERT_SAME(a_ready_idle, s_axis_tready_o, state_q == sgfa_pkg::ST_IDLE, "request taken while busy")
  `SGFA_ASSERT_NEXT(a_finish_out, in_accept && in_func == sgfa_pkg::FUNC_FINISH, m_axis_tvalid_o, "finish gave no result")

endmodule
